### rtl/lkm_pkg.sv
// Package for the line keyword matcher: shared types, register codes and the
// ASCII case-fold helper. No dependencies.
package lkm_pkg;

  localparam int MAX_KEYWORD   = 16;  // default cell count
  localparam int KW_BYTES      = 16;  // keyword bytes held by the register file
  localparam int KW_BITS       = KW_BYTES * 8;
  localparam int LEN_W         = 5;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [1:0] {
    REG_KEYWORD_LENGTH     = 2'd0,
    REG_KEYWORD_BYTES_LOW  = 2'd1,
    REG_KEYWORD_BYTES_HIGH = 2'd2,
    REG_IGNORE_CASE        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]   keyword_length;
    logic [KW_BITS-1:0] keyword_bytes;
    logic               ignore_case;
  } cfg_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic       advance;      // a request is taken this cycle
    logic       flush;        // drop stored hits after this request
    logic       ignore_case;
    logic [7:0] folded_byte;  // incoming line byte, already folded
  } cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
    logic [7:0] res;
    res = b;
    if (ic && (b >= 8'h41) && (b <= 8'h5A)) begin
      res = b + 8'h20;
    end
    return res;
  endfunction

endpackage

### rtl/lkm_cfg_regs.sv
// APB-style register file for the line keyword matcher.
// Depends on lkm_pkg for register codes and the configuration struct.
module lkm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lkm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lkm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output lkm_pkg::cfg_t                   cfg
);

  logic [lkm_pkg::LEN_W-1:0]      len_r;
  logic [lkm_pkg::CFG_DATA_W-1:0] kw_low_r;
  logic [lkm_pkg::CFG_DATA_W-1:0] kw_high_r;
  logic                           ic_r;
  logic                           wr_en;
  lkm_pkg::reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = lkm_pkg::reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      kw_low_r  <= '0;
      kw_high_r <= '0;
      ic_r      <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        lkm_pkg::REG_KEYWORD_LENGTH:     len_r     <= pwdata[lkm_pkg::LEN_W-1:0];
        lkm_pkg::REG_KEYWORD_BYTES_LOW:  kw_low_r  <= pwdata;
        lkm_pkg::REG_KEYWORD_BYTES_HIGH: kw_high_r <= pwdata;
        lkm_pkg::REG_IGNORE_CASE:        ic_r      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lkm_pkg::REG_KEYWORD_LENGTH:
        prdata = {{(lkm_pkg::CFG_DATA_W-lkm_pkg::LEN_W){1'b0}}, len_r};
      lkm_pkg::REG_KEYWORD_BYTES_LOW:  prdata = kw_low_r;
      lkm_pkg::REG_KEYWORD_BYTES_HIGH: prdata = kw_high_r;
      lkm_pkg::REG_IGNORE_CASE:
        prdata = {{(lkm_pkg::CFG_DATA_W-1){1'b0}}, ic_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.keyword_length = len_r;
  assign cfg.keyword_bytes  = {kw_high_r, kw_low_r};
  assign cfg.ignore_case    = ic_r;

endmodule

### rtl/lkm_cell.sv
// One cell of the matcher chain: holds one prefix-hit bit and compares its
// keyword byte with the incoming byte. Depends on lkm_pkg.
module lkm_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lkm_pkg::cell_ctrl_t        ctrl,
  input  logic [7:0]                 kw_byte,
  input  logic [lkm_pkg::LEN_W-1:0]  keyword_length,
  input  logic                       prev_hit,     // neighbor's stored hit
  input  logic                       prev_in_use,
  output logic                       in_use,
  output logic                       hit_calc,
  output logic                       hit_r
);

  logic hit_nxt;
  logic byte_eq;

  // In use: inside the length and no zero byte up to here.
  assign in_use   = prev_in_use && (keyword_length > lkm_pkg::LEN_W'(IDX))
                    && (kw_byte != 8'h00);
  assign byte_eq  = lkm_pkg::fold_byte(kw_byte, ctrl.ignore_case) == ctrl.folded_byte;
  assign hit_calc = prev_hit && byte_eq && in_use;
  assign hit_nxt  = ctrl.flush ? 1'b0 : hit_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.advance) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

### rtl/line_keyword_matcher_core.sv
// Line keyword matcher: reports per line whether a keyword of up to MAX_KEYWORD
// bytes occurs in it. The result of a line is registered and appears in the cycle
// after its last byte is taken. Throughput: one byte per cycle, as the cell chain
// updates on every accepted byte; input stalls only while a result waits downstream.
// Reset (rst_n, synchronous) clears registers, line state and the result valid flag.
// Depends on lkm_pkg, lkm_cfg_regs and lkm_cell.
module line_keyword_matcher_core #(
  parameter int MAX_KEYWORD = lkm_pkg::MAX_KEYWORD
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte stream
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_line_byte,
  input  logic                            in_line_end,
  // per-line result
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_line_matched,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lkm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lkm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  lkm_pkg::cfg_t        cfg;
  lkm_pkg::cell_ctrl_t  ctrl;

  logic                   in_accept;
  logic [MAX_KEYWORD-1:0] in_use;
  logic [MAX_KEYWORD-1:0] last_cell;
  logic [MAX_KEYWORD-1:0] hit_calc;
  logic [MAX_KEYWORD-1:0] hits_r;
  logic                   kw_empty;
  logic                   kill;

  logic found_r, found_nxt;
  logic zero_r, zero_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r;

  lkm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold the stream only while a finished result is still unread.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Effective keyword: cells in use form a run from cell 0; the run ends at
  // the length or at the first zero keyword byte. An empty run matches all.
  assign kw_empty  = !in_use[0];
  assign last_cell = in_use & ~(in_use >> 1);

  // A zero byte ends the searchable part of the line for good.
  assign zero_nxt  = zero_r || (in_line_byte == 8'h00);
  assign kill      = zero_nxt || kw_empty;

  assign ctrl.advance     = in_accept;
  assign ctrl.flush       = kill || in_line_end;
  assign ctrl.ignore_case = cfg.ignore_case;
  assign ctrl.folded_byte = lkm_pkg::fold_byte(in_line_byte, cfg.ignore_case);

  // Chain of cells: each takes its neighbor's stored hit on every accepted byte.
  for (genvar i = 0; i < MAX_KEYWORD; i++) begin : g_cell
    logic prev_hit;
    logic prev_in_use;
    if (i == 0) begin : g_head
      assign prev_hit    = 1'b1;
      assign prev_in_use = 1'b1;
    end else begin : g_link
      assign prev_hit    = hits_r[i-1];
      assign prev_in_use = in_use[i-1];
    end
    lkm_cell #(.IDX(i)) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .kw_byte        (cfg.keyword_bytes[8*i +: 8]),
      .keyword_length (cfg.keyword_length),
      .prev_hit       (prev_hit),
      .prev_in_use    (prev_in_use),
      .in_use         (in_use[i]),
      .hit_calc       (hit_calc[i]),
      .hit_r          (hits_r[i])
    );
  end

  // Whole keyword seen when the last cell in use hits.
  assign found_nxt = found_r || (!kill && |(hit_calc & last_cell));

  // Line state: advance on each request, drop at the line end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      zero_r  <= 1'b0;
    end else if (in_accept) begin
      if (in_line_end) begin
        found_r <= 1'b0;
        zero_r  <= 1'b0;
      end else begin
        found_r <= found_nxt;
        zero_r  <= zero_nxt;
      end
    end
  end

  // Result register: loaded on a line end, cleared once taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (in_accept && in_line_end) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_line_end) begin
      out_matched_r <= kw_empty || found_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_matched = out_matched_r;

`ifndef SYNTHESIS
  a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept && in_line_end))
    else $error("result appeared without a line end");

  a_empty_keyword_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kw_empty) |-> out_matched_r)
    else $error("empty keyword gave a non-matching line");

  a_line_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_line_end) |=> (hits_r == '0 && !found_r && !zero_r))
    else $error("line state not cleared after line end");

  a_zero_byte_kills_hits: assert property (@(posedge clk) disable iff (!rst_n)
    zero_r |-> (hits_r == '0))
    else $error("prefix hits kept after a zero byte");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for line_keyword_matcher_core: streams text bytes, checks every
// line verdict against a built-in predictor of the keyword match. Depends on lkm_pkg.
module testbench;

  localparam int LATENCY     = 1;       // verdict is registered, shown in the cycle after the line end
  localparam int CYCLE_LIMIT = 200000;  // many times the slowest legal run

  // Predictor plus store of pending line verdicts. Mirrors the matcher state:
  // a run vector of keyword prefixes ending at the current byte, a found flag
  // and a flag that a zero byte cut the searchable part of the line.
  class line_match_tracker;
    logic [4:0]  kw_len;
    logic [63:0] kw_low;
    logic [63:0] kw_high;
    logic        fold_case;
    logic [15:0] prefix_run;
    bit          line_found;
    bit          line_cut;
    bit          verdicts_due[$];
    int          fails;
    int          lines_done;
    int          lines_hit;

    function new();
      kw_len     = '0;
      kw_low     = '0;
      kw_high    = '0;
      fold_case  = 1'b0;
      fails      = 0;
      lines_done = 0;
      lines_hit  = 0;
      clear_line();
    endfunction

    function void clear_line();
      prefix_run = '0;
      line_found = 1'b0;
      line_cut   = 1'b0;
    endfunction

    function void set_reg(lkm_pkg::reg_idx_t idx, logic [63:0] value);
      case (idx)
        lkm_pkg::REG_KEYWORD_LENGTH:     kw_len = value[4:0];
        lkm_pkg::REG_KEYWORD_BYTES_LOW:  kw_low = value;
        lkm_pkg::REG_KEYWORD_BYTES_HIGH: kw_high = value;
        lkm_pkg::REG_IGNORE_CASE:        fold_case = value[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] lower_ascii(logic [7:0] b);
      if (fold_case && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
      return b;
    endfunction

    function logic [7:0] kw_at(int i);
      logic [63:0] word;
      word = (i < 8) ? kw_low : kw_high;
      return word[(i % 8) * 8 +: 8];
    endfunction

    // Usable keyword length: clip to the cell count, stop at a zero byte.
    function int kw_span();
      int n;
      n = (kw_len > 16) ? 16 : int'(kw_len);
      for (int i = 0; i < n; i++) begin
        if (kw_at(i) == 8'h00) return i;
      end
      return n;
    endfunction

    // Advance the line state by one accepted byte; queue a verdict on a line end.
    function void take_byte(logic [7:0] b, logic last);
      int          span;
      logic [15:0] hit_mask;
      span = kw_span();
      if (b == 8'h00) line_cut = 1'b1;
      if (line_cut || span == 0) begin
        prefix_run = '0;
      end else begin
        hit_mask = '0;
        for (int i = 0; i < span; i++) begin
          if (lower_ascii(kw_at(i)) == lower_ascii(b)) hit_mask[i] = 1'b1;
        end
        prefix_run = {prefix_run[14:0], 1'b1} & hit_mask;
        if (prefix_run[span-1]) line_found = 1'b1;
      end
      if (last) begin
        verdicts_due.push_back(span == 0 || line_found);
        lines_done++;
        if (span == 0 || line_found) lines_hit++;
        clear_line();
      end
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdicts_due.size() == 0) begin
        $error("line_matched: unexpected result, expected none, actual %b", got);
        fails++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $error("line_matched: expected %0b, actual %b", want, got);
        fails++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_line_byte = '0;
  logic                           in_line_end  = 1'b0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  logic                           out_line_matched;
  logic                           psel         = 1'b0;
  logic                           penable      = 1'b0;
  logic                           pwrite       = 1'b0;
  logic [lkm_pkg::CFG_ADDR_W-1:0] paddr        = '0;
  logic [lkm_pkg::CFG_DATA_W-1:0] pwdata       = '0;
  logic [lkm_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  line_match_tracker tracker = new();

  int send_idle_pct = 0;   // chance per cycle that the byte source sits idle
  int stall_pct     = 0;   // chance per cycle that the verdict sink stalls
  int hold_request  = 0;   // long sink hold-off, picked up by the sink process
  int cycle_count   = 0;
  int bytes_sent    = 0;
  int settings_used = 0;

  // Stimulus-side copy of the current keyword, used to plant matches in lines.
  logic [7:0] kw [16];
  int         kw_len_cur = 0;
  bit         kw_fold    = 1'b0;
  logic [8:0] line_q[$];   // {line_end, byte} still to send

  line_keyword_matcher_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_byte     (in_line_byte),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_matched (out_line_matched),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d verdicts pending",
               cycle_count, tracker.verdicts_due.size());
      $display("FAIL line_keyword_matcher_core");
      $finish;
    end
  end

  // Verdict sink: drive stall at each rising edge. A pending hold-off request
  // takes priority and is counted down here, cycle by cycle.
  initial begin : verdict_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Sample between edges: a verdict shown with stall low is taken at the next edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_verdict(out_line_matched);
  end

  function automatic int idle_gap(input int pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(3))
      0:       return 8'h61;  // a
      1:       return 8'h41;  // A
      2:       return 8'h62;  // b
      default: return 8'h42;  // B
    endcase
  endfunction

  // Mostly keyword-like bytes so partial prefixes build up; some wide noise.
  function automatic logic [7:0] pick_byte(input bit noisy);
    int r;
    r = $urandom_range(99);
    if (noisy || r >= 95) return 8'($urandom_range(255));
    if (r < 50) return kw[$urandom_range(15)];
    if (r < 80) return pick_letter();
    return 8'($urandom_range(126, 32));
  endfunction

  // Two-phase register write: setup cycle, then access until pready; end idle.
  task automatic write_reg(input lkm_pkg::reg_idx_t idx, input logic [63:0] value);
    bit ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Offer one byte request after a random idle gap; hold it until taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    bit taken;
    gap = idle_gap(send_idle_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_line_byte <= b;
    in_line_end  <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    tracker.take_byte(b, last);
    bytes_sent++;
  endtask

  // Drop valid, let every pending verdict arrive, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.verdicts_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // Build one line: random lead-in, often a planted keyword (case flipped
  // now and then), random tail, sometimes a zero byte dropped in.
  task automatic queue_line();
    logic [7:0] text[$];
    logic [7:0] b;
    int         n_pre;
    int         n_post;
    int         plen;
    bit         noisy;
    noisy  = ($urandom_range(9) == 0);
    n_pre  = ($urandom_range(7) == 0) ? $urandom_range(48, 20) : $urandom_range(10);
    n_post = $urandom_range(6);
    plen   = (kw_len_cur > 16) ? 16 : kw_len_cur;
    for (int k = 0; k < n_pre; k++) text.push_back(pick_byte(noisy));
    if (!noisy && plen != 0 && $urandom_range(99) < 60) begin
      for (int k = 0; k < plen; k++) begin
        b = kw[k];
        if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
            $urandom_range(99) < (kw_fold ? 50 : 10)) begin
          b = b ^ 8'h20;
        end
        text.push_back(b);
      end
    end
    for (int k = 0; k < n_post; k++) text.push_back(pick_byte(noisy));
    if (text.size() == 0) text.push_back(pick_byte(noisy));
    if ($urandom_range(6) == 0) text[$urandom_range(text.size() - 1)] = 8'h00;
    for (int k = 0; k < text.size(); k++) begin
      line_q.push_back({(k == text.size() - 1) ? 1'b1 : 1'b0, text[k]});
    end
  endtask

  // Pick and load a keyword setting. The first few settings pin the extremes:
  // full sixteen bytes, an oversized length, and the empty keyword.
  task automatic set_keyword(input int p);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] v;
    case (p)
      0:       kw_len_cur = 16;
      1:       kw_len_cur = 31;
      2:       kw_len_cur = 0;
      default: kw_len_cur = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6, 1);
    endcase
    kw_fold = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(1));
    for (int i = 0; i < 16; i++) begin
      if (p == 3) kw[i] = 8'($urandom_range(255));
      else if (p != 0 && $urandom_range(24) == 0) kw[i] = 8'h00;
      else kw[i] = pick_letter();
      if (i < 8) lo[i*8 +: 8] = kw[i];
      else hi[(i-8)*8 +: 8] = kw[i];
    end
    // Unused upper bits carry noise; the block must ignore them.
    v = {$urandom, $urandom};
    v[4:0] = 5'(kw_len_cur);
    write_reg(lkm_pkg::REG_KEYWORD_LENGTH, v);
    write_reg(lkm_pkg::REG_KEYWORD_BYTES_LOW, lo);
    write_reg(lkm_pkg::REG_KEYWORD_BYTES_HIGH, hi);
    v = {$urandom, $urandom};
    v[0] = kw_fold;
    write_reg(lkm_pkg::REG_IGNORE_CASE, v);
    settings_used++;
  endtask

  // Send a fixed number of bytes; a line left open carries into the next
  // setting, which exercises a keyword change mid-line.
  task automatic run_phase(input int n_bytes);
    logic [8:0] item;
    for (int k = 0; k < n_bytes; k++) begin
      if (line_q.size() == 0) queue_line();
      item = line_q.pop_front();
      send_byte(item[7:0], item[8]);
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty keyword after reset: every line matches, one led by a zero byte too.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain();

    // Oversized length, keyword "ab" cut short by a zero byte; exact case.
    write_reg(lkm_pkg::REG_KEYWORD_LENGTH, 64'd31);
    write_reg(lkm_pkg::REG_KEYWORD_BYTES_LOW, 64'h0000_0000_0000_6261);
    write_reg(lkm_pkg::REG_KEYWORD_BYTES_HIGH, '1);
    write_reg(lkm_pkg::REG_IGNORE_CASE, 64'd0);
    settings_used++;
    send_byte("x", 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte(8'h0A, 1'b1);
    send_byte("A", 1'b0);
    send_byte("B", 1'b1);
    drain();

    // Fold case; then a zero byte before the keyword, then one after it.
    write_reg(lkm_pkg::REG_IGNORE_CASE, 64'd1);
    settings_used++;
    send_byte("A", 1'b0);
    send_byte("B", 1'b1);
    send_byte("a", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte(8'h00, 1'b1);

    // Change the keyword to "ac" with a line open; the held prefix hit stays valid.
    send_byte("a", 1'b0);
    drain();
    write_reg(lkm_pkg::REG_KEYWORD_BYTES_LOW, 64'h0000_0000_0000_6361);
    settings_used++;
    send_byte("c", 1'b1);
    drain();

    // Full sixteen-byte keyword of all-ones bytes, short line.
    write_reg(lkm_pkg::REG_KEYWORD_LENGTH, 64'd16);
    write_reg(lkm_pkg::REG_KEYWORD_BYTES_LOW, '1);
    write_reg(lkm_pkg::REG_IGNORE_CASE, 64'd0);
    settings_used++;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // Random part: rotate through the idle profiles, one keyword setting each.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 56; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      set_keyword(p);
      // Hold off the sink long enough that the result stage fills and input stalls.
      if (p == 4) hold_request = 400;
      run_phase(125);
    end

    if (tracker.verdicts_due.size() != 0) begin
      $error("line_matched: %0d expected verdicts never arrived", tracker.verdicts_due.size());
      tracker.fails++;
    end
    $display("Sent %0d bytes in %0d lines (%0d matching) across %0d keyword settings.",
             bytes_sent, tracker.lines_done, tracker.lines_hit, settings_used);
    $display("Mismatches: %0d, cycles: %0d", tracker.fails, cycle_count);
    if (tracker.fails == 0) begin
      $display("PASS line_keyword_matcher_core");
    end else begin
      $display("FAIL line_keyword_matcher_core");
    end
    $finish;
  end

endmodule
